@@ hw/rtl/dda_pkg.sv @@
// Shared widths, command codes and fixed-point constants of the DDA line rasteriser.
package dda_pkg;

	// Coordinate and fixed-point formats
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
	localparam int STEP_BITS  = FRAC_BITS + 2;
	localparam int STEPS_BITS = COORD_BITS + 1;
	localparam int QUO_BITS   = FRAC_BITS + 1;
	localparam int NUM_BITS   = COORD_BITS + FRAC_BITS;
	localparam int CNT_BITS   = $clog2(FRAC_BITS + 1);

	// Stream payload widths, padded to whole bytes
	localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

	// Rounding constants: half a pixel, and half less one lsb for negatives
	localparam logic [ACC_BITS-1:0] ACC_HALF    = ACC_BITS'(1) << (FRAC_BITS - 1);
	localparam logic [ACC_BITS-1:0] ACC_HALF_M1 = ACC_HALF - ACC_BITS'(1);

	// Increment range limits, +1.0 and -1.0 in two's complement
	localparam logic [STEP_BITS-1:0] STEP_ONE       = STEP_BITS'(1) << FRAC_BITS;
	localparam logic [STEP_BITS-1:0] STEP_MINUS_ONE = ~STEP_ONE + STEP_BITS'(1);

	// Command codes carried on the input tuser
	typedef enum logic {
		CMD_START   = 1'b0,
		CMD_ADVANCE = 1'b1
	} cmd_t;

endpackage

@@ hw/rtl/dda_line_rasterizer.sv @@
// DDA line rasteriser: start/advance sequencer, shared restoring divider and accumulators.
//
// Input stream (s_*): one beat per command. s_tuser is the command: start loads the
// endpoints from s_tdata and prepares the line, advance emits the next pixel.
// Output stream (m_*): one beat per pixel, column and row in m_tdata, m_tlast on the
// line's final pixel. The start point itself is never emitted; a zero-length line and
// an advance with no active line produce no beat.
// A start beat of a nonzero-length line occupies the block while one restoring divider,
// one quotient bit per cycle, works out the column increment and then the row
// increment, each after a set-up state.
// An advance beat adds the increments to the accumulators as it is accepted; in the
// emit state that follows, the rounded pixel is registered in the output register.
// The next advance is not taken until the block is back in idle.
// s_tready is low while a line start is being prepared, while an advance is in its emit
// state and while a pixel sits in the output register without being taken, so a stalled
// receiver holds the block with the pixel stable on m_tdata.
// arst_n clears the line state: no line is active and the output register is empty.
module dda_line_rasterizer (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [11:0] x_start, [23:12] y_start, [35:24] x_end, [47:36] y_end
	input  logic [dda_pkg::IN_DATA_BITS-1:0]  s_tdata,
	// [0] cmd
	input  logic                              s_tuser,
	// Output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [11:0] pixel_x, [23:12] pixel_y
	output logic [dda_pkg::OUT_DATA_BITS-1:0] m_tdata,
	// last_pixel
	output logic                              m_tlast
);

	localparam int C = dda_pkg::COORD_BITS;
	localparam int F = dda_pkg::FRAC_BITS;
	localparam int A = dda_pkg::ACC_BITS;
	localparam int S = dda_pkg::STEP_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [A-1:0]                    x_accum_q, y_accum_q;
	logic [S-1:0]                    x_step_q, y_step_q;
	logic [dda_pkg::STEPS_BITS-1:0]  steps_left_q;
	logic [C-1:0]                    abs_x_q, abs_y_q, n_q;
	logic                            neg_x_q, neg_y_q;
	logic                            sel_q;
	logic [C-1:0]                    rem_q;
	logic [F:0]                      frac_q;
	logic [dda_pkg::QUO_BITS-1:0]    quo_q;
	logic [dda_pkg::CNT_BITS-1:0]    cnt_q;
	logic                            m_tvalid_q, m_tlast_q;
	logic [C-1:0]                    pix_x_q, pix_y_q;

	// Endpoint differences, magnitudes and step count
	logic [C:0]   dx, dy, ndx, ndy;
	logic [C-1:0] ax, ay, n;
	logic [C-1:0] xs, ys, xe, ye;
	logic         accept;

	assign xs = s_tdata[C-1:0];
	assign ys = s_tdata[2*C-1:C];
	assign xe = s_tdata[3*C-1:2*C];
	assign ye = s_tdata[4*C-1:3*C];

	always_comb begin
		dx  = {1'b0, xe} - {1'b0, xs};
		dy  = {1'b0, ye} - {1'b0, ys};
		ndx = -dx;
		ndy = -dy;
		ax  = dx[C] ? ndx[C-1:0] : dx[C-1:0];
		ay  = dy[C] ? ndy[C-1:0] : dy[C-1:0];
		n   = (ax > ay) ? ax : ay;
	end

	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	// Divider set-up: numerator is |d| << F plus n/2 for round-to-nearest
	logic [C-1:0]                   mag_sel;
	logic [dda_pkg::NUM_BITS-1:0]   num;

	always_comb begin
		mag_sel = sel_q ? abs_y_q : abs_x_q;
		num     = {mag_sel, {F{1'b0}}} + dda_pkg::NUM_BITS'(n_q >> 1);
	end

	// Shared restoring divider step: one quotient bit per cycle
	logic [C:0]                     trial, diff;
	logic                           ge;
	logic [C-1:0]                   rem_next;
	logic [dda_pkg::QUO_BITS-1:0]   quo_next;
	logic [S-1:0]                   mag_step, step_next;
	logic                           neg_sel;

	always_comb begin
		trial     = {rem_q, frac_q[F]};
		ge        = trial >= {1'b0, n_q};
		diff      = trial - {1'b0, n_q};
		rem_next  = ge ? diff[C-1:0] : trial[C-1:0];
		quo_next  = {quo_q[dda_pkg::QUO_BITS-2:0], ge};
		neg_sel   = sel_q ? neg_y_q : neg_x_q;
		mag_step  = {1'b0, quo_next};
		step_next = neg_sel ? -mag_step : mag_step;
	end

	// Accumulator update for an advance
	logic [A-1:0] x_sum, y_sum;

	always_comb begin
		x_sum = x_accum_q + {{(A-S){x_step_q[S-1]}}, x_step_q};
		y_sum = y_accum_q + {{(A-S){y_step_q[S-1]}}, y_step_q};
	end

	// Round half away from zero: negatives add half less one lsb, then floor
	logic [A-1:0] x_round, y_round;

	always_comb begin
		x_round = x_accum_q + (x_accum_q[A-1] ? dda_pkg::ACC_HALF_M1 : dda_pkg::ACC_HALF);
		y_round = y_accum_q + (y_accum_q[A-1] ? dda_pkg::ACC_HALF_M1 : dda_pkg::ACC_HALF);
	end

	// Sequencer, line state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			x_accum_q    <= '0;
			y_accum_q    <= '0;
			x_step_q     <= '0;
			y_step_q     <= '0;
			steps_left_q <= '0;
			abs_x_q      <= '0;
			abs_y_q      <= '0;
			n_q          <= '0;
			neg_x_q      <= 1'b0;
			neg_y_q      <= 1'b0;
			sel_q        <= 1'b0;
			rem_q        <= '0;
			frac_q       <= '0;
			quo_q        <= '0;
			cnt_q        <= '0;
			m_tvalid_q   <= 1'b0;
			m_tlast_q    <= 1'b0;
			pix_x_q      <= '0;
			pix_y_q      <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (dda_pkg::cmd_t'(s_tuser) == dda_pkg::CMD_START) begin
							x_accum_q    <= {1'b0, xs, {F{1'b0}}};
							y_accum_q    <= {1'b0, ys, {F{1'b0}}};
							x_step_q     <= '0;
							y_step_q     <= '0;
							steps_left_q <= {1'b0, n};
							abs_x_q      <= ax;
							abs_y_q      <= ay;
							neg_x_q      <= dx[C];
							neg_y_q      <= dy[C];
							n_q          <= n;
							sel_q        <= 1'b0;
							if (n != '0) begin
								state_q <= ST_SETUP;
							end
						end else if (steps_left_q != '0) begin
							x_accum_q    <= x_sum;
							y_accum_q    <= y_sum;
							steps_left_q <= steps_left_q - 1'b1;
							state_q      <= ST_EMIT;
						end
					end
				end
				ST_SETUP: begin
					rem_q   <= C'(num[dda_pkg::NUM_BITS-1:F+1]);
					frac_q  <= num[F:0];
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= rem_next;
					frac_q <= {frac_q[F-1:0], 1'b0};
					quo_q  <= quo_next;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == dda_pkg::CNT_BITS'(F)) begin
						if (sel_q) begin
							y_step_q <= step_next;
							state_q  <= ST_IDLE;
						end else begin
							x_step_q <= step_next;
							sel_q    <= 1'b1;
							state_q  <= ST_SETUP;
						end
					end
				end
				ST_EMIT: begin
					pix_x_q    <= x_round[F+C-1:F];
					pix_y_q    <= y_round[F+C-1:F];
					m_tlast_q  <= (steps_left_q == '0);
					m_tvalid_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = dda_pkg::OUT_DATA_BITS'({pix_y_q, pix_x_q});

	// A pixel only appears after the emit cycle
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_EMIT))
		else $error("output beat raised outside the emit cycle");

	// Divider remainder always stays below the divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < n_q))
		else $error("divider remainder out of range");

	// Increments never exceed one pixel in magnitude
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |->
		((x_step_q[S-1] == 1'b0 && x_step_q <= dda_pkg::STEP_ONE) ||
		 (x_step_q[S-1] == 1'b1 && x_step_q >= dda_pkg::STEP_MINUS_ONE)) &&
		((y_step_q[S-1] == 1'b0 && y_step_q <= dda_pkg::STEP_ONE) ||
		 (y_step_q[S-1] == 1'b1 && y_step_q >= dda_pkg::STEP_MINUS_ONE)))
		else $error("increment magnitude above one");

	// A pending final pixel means the line is exhausted
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (steps_left_q == '0))
		else $error("final pixel flagged with steps remaining");

endmodule
